/* design/kvt_pkg.sv */
package kvt_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam logic [4:0] CAP_RESET  = 5'd16;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Per-cycle commands broadcast along the row of cells
    typedef struct packed {
        logic delete_en;
        logic update_en;
        logic append_en;
    } kvt_ctrl_t;

endpackage

/* design/key_value_table.sv */
// key_value_table: associative table of unique 32-bit keys, one payload word per key, held
// densely packed in insertion order in a row of cells, one entry to a cell. Each input word
// is an insert-or-update, a lookup or a delete (kind 3 leaves the table untouched and
// reports failure), and yields exactly one result word with a success flag, the payload on
// a successful lookup (zero otherwise) and the entry count after the request. Each word is
// first captured in the request registers; then every cell compares its key at once and the
// row updates, appends or shifts down by one place on a delete. The execute cycle
// is held while a previous result waits in the output register under out_stall. There is
// no clearing pass after reset; the table comes up empty. capacity_limit may be written
// only while the table is idle and saturates at DEPTH; lowering it below the count keeps
// the existing entries.
module key_value_table #(
    parameter int DEPTH      = kvt_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] lookup_key,
    input  logic [31:0]        value_word,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               success,
    output logic [31:0]        value_out,
    output logic [4:0]         entry_count
);
    import kvt_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    // control state
    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [4:0]      cap_reg;
    logic            out_valid_reg;
    logic            out_valid_next;

    // captured request word
    logic [1:0]            req_kind_reg;
    logic [31:0]           req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    // result register
    logic        success_reg;
    logic        success_next;
    logic [31:0] value_out_reg;
    logic [31:0] value_out_next;
    logic [4:0]  count_out_reg;

    // row wiring
    logic [31:0]           cell_key   [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      shift_out;
    logic                  any_match;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  room;
    logic                  commit;
    logic                  accept;
    kvt_ctrl_t             ctrl;

    assign accept    = in_valid && !in_stall;
    // Commit only when the output register is free to take the result
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign any_match = |match;
    assign room      = (CMPW'(count_reg) < CMPW'(cap_reg)) && (CMPW'(count_reg) < CMPW'(DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_EXEC: in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    // Decode the captured kind into row commands and the result word
    always_comb
    begin
        ctrl           = '0;
        success_next   = 1'b0;
        value_out_next = '0;
        count_next     = count_reg;
        unique case (req_kind_reg)
            KIND_INSERT:
            begin
                ctrl.update_en = commit && any_match;
                ctrl.append_en = commit && !any_match && room;
                success_next   = any_match || room;
                if (!any_match && room)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_LOOKUP:
            begin
                success_next = any_match;
                if (any_match)
                begin
                    value_out_next = 32'(hit_value);
                end
            end
            KIND_DELETE:
            begin
                ctrl.delete_en = commit && any_match;
                success_next   = any_match;
                if (any_match)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    // Keys are unique, so at most one cell drives the hit value
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_value = hit_value | (match[i] ? cell_value[i] : '0);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                  shift_in;
            logic [31:0]           up_key;
            logic [VALUE_BITS-1:0] up_value;

            if (gi == 0)
            begin : g_first
                assign shift_in = 1'b0;
            end
            else
            begin : g_rest
                assign shift_in = shift_out[gi-1];
            end

            // The top cell loads its own contents; it drops out of use on a delete
            if (gi == DEPTH - 1)
            begin : g_top
                assign up_key   = cell_key[gi];
                assign up_value = cell_value[gi];
            end
            else
            begin : g_below
                assign up_key   = cell_key[gi+1];
                assign up_value = cell_value[gi+1];
            end

            kvt_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occupied (CW'(gi) < count_reg),
                .tail     (CW'(gi) == count_reg),
                .req_key  (req_key_reg),
                .req_value(req_value_reg),
                .up_key   (up_key),
                .up_value (up_value),
                .shift_in (shift_in),
                .key      (cell_key[gi]),
                .value    (cell_value[gi]),
                .match    (match[gi]),
                .shift_out(shift_out[gi])
            );
        end
    endgenerate

    // Hold the result while stalled, drop it once taken
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg  <= kind;
            req_key_reg   <= lookup_key;
            req_value_reg <= VALUE_BITS'(value_word);
        end
        if (commit)
        begin
            success_reg   <= success_next;
            value_out_reg <= value_out_next;
            count_out_reg <= 5'(count_next);
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_out_reg;

    // Unique keys: no two occupied cells may ever match the same request
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("more than one cell matches the request key");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count moved without a commit");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && out_stall) |=> (state_reg == ST_EXEC))
        else $error("request left execute while the result slot was full");

endmodule

/* design/kvt_cell.sv */
module kvt_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  kvt_pkg::kvt_ctrl_t    ctrl,
    input  logic                  occupied,
    input  logic                  tail,
    input  logic [31:0]           req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    input  logic [31:0]           up_key,
    input  logic [VALUE_BITS-1:0] up_value,
    input  logic                  shift_in,
    output logic [31:0]           key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  match,
    output logic                  shift_out
);
    import kvt_pkg::*;

    logic [31:0]           key_reg;
    logic [31:0]           key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    assign match     = occupied && (key_reg == req_key);
    // Everything at or above the deleted entry moves down one place
    assign shift_out = shift_in | match;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.delete_en && shift_out)
        begin
            key_next   = up_key;
            value_next = up_value;
        end
        else if (ctrl.update_en && match)
        begin
            value_next = req_value;
        end
        else if (ctrl.append_en && tail)
        begin
            key_next   = req_key;
            value_next = req_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import kvt_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLDOFF_CYCLES = 120;
    localparam int QUIET_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 60;

    // Kind 3 has no member in the package enum; name it here.
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic        ok;
        logic [31:0] value;
        logic [4:0]  count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = '0;
    logic signed [31:0] lookup_key = '0;
    logic [31:0] value_word = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic success;
    logic [31:0] value_out;
    logic [4:0] entry_count;

    key_value_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .lookup_key  (lookup_key),
        .value_word  (value_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .success     (success),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow copy of the table, advanced once per accepted request word
    logic [31:0] shadow_keys   [DEPTH];
    logic [31:0] shadow_values [DEPTH];
    int          shadow_fill = 0;
    logic [4:0]  capacity_setting = CAP_RESET;

    request_t      pending_requests[$];
    table_result_t expected_results[$];
    logic [31:0]   key_pool[$];

    int requests_queued   = 0;
    int requests_accepted = 0;
    int results_checked   = 0;
    int mismatch_count    = 0;
    int settings_written  = 0;
    int full_refusals     = 0;
    int lookup_hits       = 0;
    int deletes_done      = 0;
    int highest_fill      = 0;
    int holdoff_asked     = 0;
    int holdoff_done      = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Work out the result word of one request and advance the shadow table.
    // Keys match as raw 32-bit patterns; the sign plays no part.
    function automatic table_result_t apply_request(input request_t req);
        table_result_t res;
        int hit;
        int room;
        hit = -1;
        room = (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
        res.ok = 1'b0;
        res.value = '0;
        for (int i = 0; i < shadow_fill; i++)
            if (hit < 0 && shadow_keys[i] == req.key)
                hit = i;
        if (req.kind == KIND_INSERT) begin
            if (hit >= 0) begin
                shadow_values[hit] = req.value;
                res.ok = 1'b1;
            end else if (shadow_fill < room) begin
                shadow_keys[shadow_fill] = req.key;
                shadow_values[shadow_fill] = req.value;
                shadow_fill++;
                res.ok = 1'b1;
            end else begin
                full_refusals++;
            end
        end else if (req.kind == KIND_LOOKUP) begin
            if (hit >= 0) begin
                res.value = shadow_values[hit];
                res.ok = 1'b1;
                lookup_hits++;
            end
        end else if (req.kind == KIND_DELETE) begin
            if (hit >= 0) begin
                // close the gap: later entries move down one place
                for (int j = hit; j + 1 < shadow_fill; j++) begin
                    shadow_keys[j] = shadow_keys[j + 1];
                    shadow_values[j] = shadow_values[j + 1];
                end
                shadow_fill--;
                res.ok = 1'b1;
                deletes_done++;
            end
        end
        if (shadow_fill > highest_fill)
            highest_fill = shadow_fill;
        res.count = 5'(shadow_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: hold a stalled word, otherwise advance through the
    // pending queue with random gaps between words.
    // ------------------------------------------------------------------
    request_t driven_request;
    int       send_gap = 0;
    bit       send_calm = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                send_calm = ~send_calm;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_request(driven_request));
                requests_accepted++;
            end
            if (in_valid && in_stall)
            begin
                // hold the word steady until the table takes it
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_requests.size() != 0)
            begin
                driven_request = pending_requests.pop_front();
                kind       <= driven_request.kind;
                lookup_key <= driven_request.key;
                value_word <= driven_request.value;
                in_valid   <= 1'b1;
                if (!send_calm && $urandom_range(0, 99) < 35)
                    send_gap = gap_length();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted result word against the oldest
    // expectation, and drive out_stall (random stalls plus the long
    // hold-off asked for by the stimulus).
    // ------------------------------------------------------------------
    int  stall_left = 0;
    bit  stall_calm = 1'b0;
    table_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word with nothing outstanding (count %0d)",
                                              entry_count));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (success !== want.ok)
                        report_mismatch($sformatf("success %b, expected %b", success, want.ok));
                    if (value_out !== want.value)
                        report_mismatch($sformatf("value_out %h, expected %h",
                                                  value_out, want.value));
                    if (entry_count !== want.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  entry_count, want.count));
                end
            end

            if ($urandom_range(0, 199) == 0)
                stall_calm = ~stall_calm;
            if (holdoff_done != holdoff_asked)
            begin
                holdoff_done++;
                stall_left = HOLDOFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!stall_calm && $urandom_range(0, 99) < 20)
            begin
                out_stall <= 1'b1;
                stall_left = gap_length() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a word
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no traffic for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [1:0] k, input logic [31:0] key,
                                 input logic [31:0] value);
        request_t req;
        req.kind  = k;
        req.key   = key;
        req.value = value;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Mostly keys from a small pool so that hits, updates and a full table
    // are common; some near misses (one bit flipped) and some fresh keys.
    function automatic logic [31:0] pick_key();
        int r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 8)
            return $urandom;
        else if (r < 18)
            return k ^ (32'd1 << $urandom_range(0, 31));
        return k;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_random(input int n, input int insert_pct);
        int r;
        logic [1:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                k = KIND_INSERT;
            else if (r < insert_pct + (100 - insert_pct) * 55 / 100)
                k = KIND_LOOKUP;
            else if (r < 96)
                k = KIND_DELETE;
            else
                k = KIND_UNDEFINED;
            queue_request(k, pick_key(), pick_value());
        end
    endtask

    // Wait until every queued word is taken and every result is back,
    // then let the pipeline settle.
    task automatic wait_for_drain();
        while (requests_accepted != requests_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] setting);
        wait_for_drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do @(posedge clk); while (!cfg_ready);
        capacity_setting = setting;
        settings_written++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        key_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001};
        for (int i = 0; i < 19; i++)
            key_pool.push_back($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, key extremes, update, shift on delete,
        // the undefined kind with and without entries.
        queue_request(KIND_LOOKUP,    32'h0000_0000, 32'h0);
        queue_request(KIND_DELETE,    32'h0000_0000, 32'h0);
        queue_request(KIND_UNDEFINED, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(KIND_INSERT,    32'h8000_0000, 32'h0000_0000);
        queue_request(KIND_INSERT,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(KIND_INSERT,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
        queue_request(KIND_INSERT,    32'h0000_0000, 32'h5A5A_5A5A);
        queue_request(KIND_INSERT,    32'h7FFF_FFFE, 32'h0000_0001);
        queue_request(KIND_LOOKUP,    32'h8000_0000, 32'h0);
        queue_request(KIND_LOOKUP,    32'h7FFF_FFFF, 32'h0);
        queue_request(KIND_LOOKUP,    32'h7FFF_FFFE, 32'h0);
        queue_request(KIND_LOOKUP,    32'h0000_0001, 32'h0);
        queue_request(KIND_INSERT,    32'h7FFF_FFFF, 32'h1234_5678);
        queue_request(KIND_LOOKUP,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(KIND_UNDEFINED, 32'h7FFF_FFFF, 32'h0);
        queue_request(KIND_DELETE,    32'hFFFF_FFFF, 32'h0);
        queue_request(KIND_LOOKUP,    32'h0000_0000, 32'h0);
        queue_request(KIND_LOOKUP,    32'hFFFF_FFFF, 32'h0);
        queue_request(KIND_DELETE,    32'h8000_0000, 32'h0);
        queue_request(KIND_DELETE,    32'h7FFF_FFFE, 32'h0);
        queue_request(KIND_DELETE,    32'h7FFF_FFFE, 32'h0);
        queue_request(KIND_LOOKUP,    32'h7FFF_FFFF, 32'h0);

        // Capacity zero: new keys are refused, existing ones still work
        write_capacity(5'd0);
        queue_request(KIND_INSERT, 32'h0000_0001, 32'hDEAD_BEEF);
        queue_request(KIND_INSERT, 32'h0000_0000, 32'hCAFE_F00D);
        queue_request(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        queue_request(KIND_DELETE, 32'h0000_0000, 32'h0);
        queue_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0002);
        queue_random(80, 40);

        // Full capacity; ask for a long hold-off on the result side while
        // words keep coming, so the table backs up and stalls its input.
        write_capacity(CAP_RESET);
        queue_random(150, 60);
        holdoff_asked++;
        // Pause sending until every result has come, then carry on
        wait_for_drain();
        queue_random(120, 45);

        // Above the built depth: saturates at DEPTH
        write_capacity(5'd31);
        queue_random(250, 55);

        // Lowered below the current count: entries stay, appends refused
        write_capacity(5'd3);
        queue_random(150, 45);

        write_capacity(5'd1);
        queue_random(100, 50);

        write_capacity(5'd16);
        queue_random(150, 55);

        wait_for_drain();
        while (expected_results.size() != 0)
            report_mismatch("result word never arrived");

        $display("Run covered %0d request words and %0d result words over %0d capacity writes.",
                 requests_accepted, results_checked, settings_written);
        $display("Lookup hits %0d, deletes %0d, inserts refused when full %0d, peak fill %0d.",
                 lookup_hits, deletes_done, full_refusals, highest_fill);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
design/kvt_pkg.sv
design/kvt_cell.sv
design/key_value_table.sv
sim/testbench.sv
